// File: hdl/itnt_pkg.sv
// Package: types, widths and reset constants for the inverse-transpose normal transform
package itnt_pkg;

   localparam int LimitWidth = 40;
   localparam logic [LimitWidth-1:0] LimitReset = 40'd687;

   typedef struct packed {
      logic signed [15:0] m_00;
      logic signed [15:0] m_01;
      logic signed [15:0] m_02;
      logic signed [15:0] m_10;
      logic signed [15:0] m_11;
      logic signed [15:0] m_12;
      logic signed [15:0] m_20;
      logic signed [15:0] m_21;
      logic signed [15:0] m_22;
      logic signed [15:0] in_nx;
      logic signed [15:0] in_ny;
      logic signed [15:0] in_nz;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic signed [15:0] out_nx;
      logic signed [15:0] out_ny;
      logic signed [15:0] out_nz;
   } rsp_word_type;

   // Per-item control carried beside the vector data
   typedef struct packed {
      logic reject;
      logic flip;
      logic neg_x;
      logic neg_y;
      logic neg_z;
   } item_ctl_type;

   // Normalized magnitude, first set bit at 29
   function automatic logic [29:0] norm_mag(input logic [49:0] mag, input logic [5:0] msb);
      logic [79:0] wide;
      begin
         wide = {30'd0, mag};
         if (msb >= 6'd29) begin
            wide = wide >> (msb - 6'd29);
         end else begin
            wide = wide << (6'd29 - msb);
         end
         norm_mag = wide[29:0];
      end
   endfunction

endpackage

// File: hdl/itnt_front.sv
// Front stages: cofactors, determinant, transformed vector, singular test
module itnt_front
   import itnt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  req_word_type          in_word,
   input  logic [LimitWidth-1:0] limit,
   output logic                  out_valid,
   output item_ctl_type          out_ctl,
   output logic [49:0]           out_mx,
   output logic [49:0]           out_my,
   output logic [49:0]           out_mz
);

   // stage A: cofactors
   logic               va_ff;
   logic signed [32:0] c_ff [9];
   logic signed [32:0] c_in [9];
   logic signed [15:0] m0_ff, m1_ff, m2_ff, sx_ff, sy_ff, sz_ff;

   always_comb begin
      c_in[0] = 33'(in_word.m_11 * in_word.m_22) - 33'(in_word.m_12 * in_word.m_21);
      c_in[1] = 33'(in_word.m_12 * in_word.m_20) - 33'(in_word.m_10 * in_word.m_22);
      c_in[2] = 33'(in_word.m_10 * in_word.m_21) - 33'(in_word.m_11 * in_word.m_20);
      c_in[3] = 33'(in_word.m_02 * in_word.m_21) - 33'(in_word.m_01 * in_word.m_22);
      c_in[4] = 33'(in_word.m_00 * in_word.m_22) - 33'(in_word.m_02 * in_word.m_20);
      c_in[5] = 33'(in_word.m_01 * in_word.m_20) - 33'(in_word.m_00 * in_word.m_21);
      c_in[6] = 33'(in_word.m_01 * in_word.m_12) - 33'(in_word.m_02 * in_word.m_11);
      c_in[7] = 33'(in_word.m_02 * in_word.m_10) - 33'(in_word.m_00 * in_word.m_12);
      c_in[8] = 33'(in_word.m_00 * in_word.m_11) - 33'(in_word.m_01 * in_word.m_10);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
      end
      if (adv) begin
         for (int i = 0; i < 9; i++) c_ff[i] <= c_in[i];
         m0_ff <= in_word.m_00;
         m1_ff <= in_word.m_01;
         m2_ff <= in_word.m_02;
         sx_ff <= in_word.in_nx;
         sy_ff <= in_word.in_ny;
         sz_ff <= in_word.in_nz;
      end
   end

   // stage B: products
   logic               vb_ff;
   logic signed [48:0] p_ff [12];
   logic signed [48:0] p_in [12];

   always_comb begin
      p_in[0] = 49'(m0_ff * c_ff[0]);
      p_in[1] = 49'(m1_ff * c_ff[1]);
      p_in[2] = 49'(m2_ff * c_ff[2]);
      for (int r = 0; r < 3; r++) begin
         p_in[3 + 3*r] = 49'(c_ff[3*r] * sx_ff);
         p_in[4 + 3*r] = 49'(c_ff[3*r+1] * sy_ff);
         p_in[5 + 3*r] = 49'(c_ff[3*r+2] * sz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
      if (adv) begin
         for (int i = 0; i < 12; i++) p_ff[i] <= p_in[i];
      end
   end

   // stage C: sums, magnitudes, rejection
   logic               vc_ff;
   item_ctl_type       ctl_ff, ctl_in;
   logic [49:0]        mx_ff, my_ff, mz_ff, mx_in, my_in, mz_in;
   logic signed [50:0] det, wx, wy, wz;
   logic [50:0]        adet;

   always_comb begin
      det = 51'(p_ff[0]) + 51'(p_ff[1]) + 51'(p_ff[2]);
      wx  = 51'(p_ff[3]) + 51'(p_ff[4]) + 51'(p_ff[5]);
      wy  = 51'(p_ff[6]) + 51'(p_ff[7]) + 51'(p_ff[8]);
      wz  = 51'(p_ff[9]) + 51'(p_ff[10]) + 51'(p_ff[11]);
      adet = det[50] ? 51'(-det) : 51'(det);
      mx_in = wx[50] ? 50'(-wx) : 50'(wx);
      my_in = wy[50] ? 50'(-wy) : 50'(wy);
      mz_in = wz[50] ? 50'(-wz) : 50'(wz);
      ctl_in.flip  = det[50];
      ctl_in.neg_x = wx[50];
      ctl_in.neg_y = wy[50];
      ctl_in.neg_z = wz[50];
      ctl_in.reject = (adet <= 51'(limit)) ||
                      ((mx_in | my_in | mz_in) == 50'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff;
      end
      if (adv) begin
         ctl_ff <= ctl_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         mz_ff  <= mz_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_ctl   = ctl_ff;
   assign out_mx    = mx_ff;
   assign out_my    = my_ff;
   assign out_mz    = mz_ff;

endmodule

// File: hdl/itnt_norm.sv
// Normalize stages: block shift, sum of squares, pipelined square root
module itnt_norm
   import itnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  item_ctl_type in_ctl,
   input  logic [49:0]  in_mx,
   input  logic [49:0]  in_my,
   input  logic [49:0]  in_mz,
   output logic         out_valid,
   output item_ctl_type out_ctl,
   output logic [29:0]  out_ux,
   output logic [29:0]  out_uy,
   output logic [29:0]  out_uz,
   output logic [31:0]  out_len
);

   // stage D: leading one of the largest, then shift
   logic         vd_ff;
   item_ctl_type ctl_d_ff;
   logic [29:0]  ux_ff, uy_ff, uz_ff, ux_in, uy_in, uz_in;
   logic [49:0]  orv;
   logic [5:0]   msb;

   always_comb begin
      orv = in_mx | in_my | in_mz;
      msb = 6'd0;
      for (int i = 0; i < 50; i++) begin
         if (orv[i]) msb = 6'(i);
      end
      ux_in = norm_mag(in_mx, msb);
      uy_in = norm_mag(in_my, msb);
      uz_in = norm_mag(in_mz, msb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= in_valid;
      end
      if (adv) begin
         ctl_d_ff <= in_ctl;
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         uz_ff <= uz_in;
      end
   end

   // stage E: squares
   logic         ve_ff;
   item_ctl_type ctl_e_ff;
   logic [29:0]  ux_e_ff, uy_e_ff, uz_e_ff;
   logic [59:0]  qx_ff, qy_ff, qz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= vd_ff;
      end
      if (adv) begin
         ctl_e_ff <= ctl_d_ff;
         ux_e_ff <= ux_ff;
         uy_e_ff <= uy_ff;
         uz_e_ff <= uz_ff;
         qx_ff <= ux_ff * ux_ff;
         qy_ff <= uy_ff * uy_ff;
         qz_ff <= uz_ff * uz_ff;
      end
   end

   // square root: 32 result bits, 4 per stage over 8 stages, sum below 2^62
   localparam int Stages = 8;
   localparam int BitsPer = 4;

   logic         vs_ff   [Stages+1];
   item_ctl_type ctl_s_ff[Stages+1];
   logic [29:0]  sx_ff [Stages+1], sy_ff [Stages+1], sz_ff [Stages+1];
   logic [63:0]  rem_ff[Stages+1];
   logic [31:0]  root_ff[Stages+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff[0] <= 1'b0;
      end else if (adv) begin
         vs_ff[0] <= ve_ff;
      end
      if (adv) begin
         ctl_s_ff[0] <= ctl_e_ff;
         sx_ff[0] <= ux_e_ff;
         sy_ff[0] <= uy_e_ff;
         sz_ff[0] <= uz_e_ff;
         rem_ff[0] <= 64'(qx_ff) + 64'(qy_ff) + 64'(qz_ff);
         root_ff[0] <= 32'd0;
      end
   end

   for (genvar g = 0; g < Stages; g++) begin : g_sqrt
      logic [63:0] rem_c;
      logic [31:0] root_c;
      logic [63:0] trial;

      // restoring digit recurrence, one result bit per step
      always_comb begin
         rem_c  = rem_ff[g];
         root_c = root_ff[g];
         trial  = 64'd0;
         for (int k = 0; k < BitsPer; k++) begin
            trial = (64'(root_c) << (32 - (g * BitsPer + k))) |
                    (64'd1 << (2 * (31 - (g * BitsPer + k))));
            if (rem_c >= trial) begin
               rem_c  = rem_c - trial;
               root_c = root_c | (32'd1 << (31 - (g * BitsPer + k)));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[g+1] <= 1'b0;
         end else if (adv) begin
            vs_ff[g+1] <= vs_ff[g];
         end
         if (adv) begin
            ctl_s_ff[g+1] <= ctl_s_ff[g];
            sx_ff[g+1] <= sx_ff[g];
            sy_ff[g+1] <= sy_ff[g];
            sz_ff[g+1] <= sz_ff[g];
            rem_ff[g+1] <= rem_c;
            root_ff[g+1] <= root_c;
         end
      end
   end

   assign out_valid = vs_ff[Stages];
   assign out_ctl   = ctl_s_ff[Stages];
   assign out_ux    = sx_ff[Stages];
   assign out_uy    = sy_ff[Stages];
   assign out_uz    = sz_ff[Stages];
   assign out_len   = root_ff[Stages];

endmodule

// File: hdl/itnt_divide.sv
// Divide stages: three pipelined quotient units, 15 quotient bits each
module itnt_divide
   import itnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  item_ctl_type in_ctl,
   input  logic [29:0]  in_ux,
   input  logic [29:0]  in_uy,
   input  logic [29:0]  in_uz,
   input  logic [31:0]  in_len,
   output logic         out_valid,
   output rsp_word_type out_word
);

   // quotient (u*16384 + len/2) / len is at most 16384: 15 bits
   localparam int QBits = 15;
   localparam int Stages = 5;
   localparam int BitsPer = 3;

   logic         v_ff  [Stages+1];
   item_ctl_type ctl_ff[Stages+1];
   logic [31:0]  len_ff[Stages+1];
   logic [45:0]  num_ff[Stages+1][3];
   logic [14:0]  q_ff  [Stages+1][3];

   // numerator load
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         ctl_ff[0] <= in_ctl;
         len_ff[0] <= in_len;
         num_ff[0][0] <= {2'd0, in_ux, 14'd0} + 46'(in_len >> 1);
         num_ff[0][1] <= {2'd0, in_uy, 14'd0} + 46'(in_len >> 1);
         num_ff[0][2] <= {2'd0, in_uz, 14'd0} + 46'(in_len >> 1);
         for (int j = 0; j < 3; j++) q_ff[0][j] <= 15'd0;
      end
   end

   for (genvar g = 0; g < Stages; g++) begin : g_div
      logic [45:0] num_c [3];
      logic [14:0] q_c   [3];
      logic [45:0] sub;

      // long division, one quotient bit per step
      always_comb begin
         sub = 46'd0;
         for (int j = 0; j < 3; j++) begin
            num_c[j] = num_ff[g][j];
            q_c[j]   = q_ff[g][j];
            for (int k = 0; k < BitsPer; k++) begin
               sub = 46'(len_ff[g]) << (QBits - 1 - (g * BitsPer + k));
               if (num_c[j] >= sub) begin
                  num_c[j] = num_c[j] - sub;
                  q_c[j] = q_c[j] | (15'd1 << (QBits - 1 - (g * BitsPer + k)));
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (adv) begin
            ctl_ff[g+1] <= ctl_ff[g];
            len_ff[g+1] <= len_ff[g];
            for (int j = 0; j < 3; j++) begin
               num_ff[g+1][j] <= num_c[j];
               q_ff[g+1][j]   <= q_c[j];
            end
         end
      end
   end

   // sign and rejection
   item_ctl_type c;
   logic [15:0]  qx, qy, qz;

   always_comb begin
      c  = ctl_ff[Stages];
      qx = {1'b0, q_ff[Stages][0]};
      qy = {1'b0, q_ff[Stages][1]};
      qz = {1'b0, q_ff[Stages][2]};
      out_word.ok     = !c.reject;
      out_word.out_nx = c.reject ? 16'sd0 : ((c.neg_x ^ c.flip) ? -qx : qx);
      out_word.out_ny = c.reject ? 16'sd0 : ((c.neg_y ^ c.flip) ? -qy : qy);
      out_word.out_nz = c.reject ? 16'sd0 : ((c.neg_z ^ c.flip) ? -qz : qz);
   end

   assign out_valid = v_ff[Stages];

endmodule

// File: hdl/inverse_transpose_normal_transform_top.sv
// Top level: limit register, pipeline stages and output handshake
// Throughput: one word per cycle; a stall holds the whole pipeline in place.
// req_stall follows rsp_stall and a full last stage; the output register holds its word.
// Reset (synchronous, active high) clears all valid bits and sets limit_ff to 687.
module inverse_transpose_normal_transform_top
   import itnt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LimitWidth-1:0] csr_data
);

   logic [LimitWidth-1:0] limit_ff;
   logic                  adv;
   logic                  f_valid, n_valid, d_valid;
   item_ctl_type          f_ctl, n_ctl;
   logic [49:0]           f_mx, f_my, f_mz;
   logic [29:0]           n_ux, n_uy, n_uz;
   logic [31:0]           n_len;
   rsp_word_type          d_word, out_ff;
   logic                  out_v_ff;

   assign csr_ready = 1'b1;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // pipeline moves when the output register is free or being taken
   assign adv       = !out_v_ff || !rsp_stall;
   assign req_stall = !adv;

   itnt_front u_front (
      .clock, .reset, .adv,
      .in_valid (req_valid), .in_word (req_word), .limit (limit_ff),
      .out_valid(f_valid), .out_ctl(f_ctl),
      .out_mx(f_mx), .out_my(f_my), .out_mz(f_mz)
   );

   itnt_norm u_norm (
      .clock, .reset, .adv,
      .in_valid(f_valid), .in_ctl(f_ctl),
      .in_mx(f_mx), .in_my(f_my), .in_mz(f_mz),
      .out_valid(n_valid), .out_ctl(n_ctl),
      .out_ux(n_ux), .out_uy(n_uy), .out_uz(n_uz), .out_len(n_len)
   );

   itnt_divide u_divide (
      .clock, .reset, .adv,
      .in_valid(n_valid), .in_ctl(n_ctl),
      .in_ux(n_ux), .in_uy(n_uy), .in_uz(n_uz), .in_len(n_len),
      .out_valid(d_valid), .out_word(d_word)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= d_valid;
      end
      if (adv) begin
         out_ff <= d_word;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

   // a rejected word carries a zero vector
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.ok |->
         rsp_word.out_nx == 16'sd0 && rsp_word.out_ny == 16'sd0 &&
         rsp_word.out_nz == 16'sd0)
      else $error("rejected word has nonzero vector");

   // accepted x component stays within unit range
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.ok |->
         rsp_word.out_nx <= 16'sd16384 && rsp_word.out_nx >= -16'sd16384)
      else $error("x component out of range");

   // input stalls only while the output word is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

endmodule

// File: bench/inverse_transpose_normal_transform_top_test.sv
// Testbench: random and directed checks of the inverse-transpose normal transform
`timescale 1ns / 1ps

module inverse_transpose_normal_transform_top_test;
   import itnt_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_word_type          rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LimitWidth-1:0] csr_data;

   inverse_transpose_normal_transform_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Bench copy of the limit register and the normals still owed
   logic [LimitWidth-1:0] limit_copy;
   rsp_word_type          pending_normals[$];
   int                    errors;
   bit                    quiet;
   int                    hold_cycles;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type r;
   } vector_row_type;

   vector_row_type vector_rows[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Exact integer square root, floor
   function automatic longint unsigned floor_sqrt(input longint unsigned op);
      longint unsigned res;
      longint unsigned b;
      begin
         res = 0;
         b = 64'd1 << 62;
         while (b > op) b = b >> 2;
         while (b != 0) begin
            if (op >= res + b) begin
               op = op - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      end
   endfunction

   // Cofactor product of the normal, scaled to a Q1.14 unit vector
   function automatic rsp_word_type predict_normal(input req_word_type w,
                                                   input logic [LimitWidth-1:0] lim);
      longint m[9];
      longint s[3];
      longint c[9];
      longint v[3];
      longint det;
      longint unsigned adet;
      longint unsigned mag[3];
      longint unsigned amax;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      bit wneg[3];
      bit detneg;
      rsp_word_type r;
      logic signed [15:0] o[3];
      begin
         m[0] = w.m_00; m[1] = w.m_01; m[2] = w.m_02;
         m[3] = w.m_10; m[4] = w.m_11; m[5] = w.m_12;
         m[6] = w.m_20; m[7] = w.m_21; m[8] = w.m_22;
         s[0] = w.in_nx; s[1] = w.in_ny; s[2] = w.in_nz;
         c[0] = m[4] * m[8] - m[5] * m[7];
         c[1] = m[5] * m[6] - m[3] * m[8];
         c[2] = m[3] * m[7] - m[4] * m[6];
         c[3] = m[2] * m[7] - m[1] * m[8];
         c[4] = m[0] * m[8] - m[2] * m[6];
         c[5] = m[1] * m[6] - m[0] * m[7];
         c[6] = m[1] * m[5] - m[2] * m[4];
         c[7] = m[2] * m[3] - m[0] * m[5];
         c[8] = m[0] * m[4] - m[1] * m[3];
         det = m[0] * c[0] + m[1] * c[1] + m[2] * c[2];
         detneg = det < 0;
         adet = detneg ? -det : det;
         r = '0;
         if (adet <= lim) return r;
         amax = 0;
         for (int i = 0; i < 3; i++) begin
            v[i] = c[i*3] * s[0] + c[i*3+1] * s[1] + c[i*3+2] * s[2];
            wneg[i] = v[i] < 0;
            mag[i] = wneg[i] ? -v[i] : v[i];
            if (mag[i] > amax) amax = mag[i];
         end
         if (amax == 0) return r;
         while (amax >= (64'd1 << 30)) begin
            amax = amax >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         while (amax < (64'd1 << 29)) begin
            amax = amax << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         len = floor_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            o[i] = (wneg[i] != detneg) ? -q[15:0] : q[15:0];
         end
         r.ok = 1'b1;
         r.out_nx = o[0];
         r.out_ny = o[1];
         r.out_nz = o[2];
         return r;
      end
   endfunction

   function automatic req_word_type diag_word(input logic signed [15:0] d0, d1, d2,
                                              input logic signed [15:0] nx, ny, nz);
      req_word_type w;
      begin
         w = '0;
         w.m_00 = d0; w.m_11 = d1; w.m_22 = d2;
         w.in_nx = nx; w.in_ny = ny; w.in_nz = nz;
         return w;
      end
   endfunction

   // Random item: full range mostly, small entries for near-singular cases
   function automatic req_word_type random_word();
      req_word_type w;
      int mode;
      begin
         w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         mode = $urandom_range(0, 9);
         if (mode < 3) begin
            w.m_00 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_01 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_02 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_10 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_11 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_12 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_20 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_21 = 16'($signed($urandom_range(0, 8)) - 4);
            w.m_22 = 16'($signed($urandom_range(0, 8)) - 4);
         end else if (mode == 3) begin
            // rank-deficient: last row copies the first
            w.m_20 = w.m_00; w.m_21 = w.m_01; w.m_22 = w.m_02;
         end else if (mode == 4) begin
            w.in_nx = 16'($signed($urandom_range(0, 2)) - 1);
            w.in_ny = 16'($signed($urandom_range(0, 2)) - 1);
            w.in_nz = 16'($signed($urandom_range(0, 2)) - 1);
         end
         return w;
      end
   endfunction

   // Offer one word; valid stays high into the next word unless a gap is drawn
   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type r);
      bit taken;
      begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_word <= w;
         taken = 1'b0;
         while (!taken) begin
            @(posedge clock);
            taken = req_valid && !req_stall;
            if (!taken) @(negedge clock);
         end
         pending_normals.insert(pending_normals.size(),
                                typed ? r : predict_normal(w, limit_copy));
      end
   endtask

   task automatic drain();
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (pending_normals.size() != 0) @(posedge clock);
         repeat (DrainCycles) @(posedge clock);
      end
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] value);
      bit done;
      begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_data <= value;
         done = 1'b0;
         while (!done) begin
            @(posedge clock);
            done = csr_ready;
         end
         @(negedge clock);
         csr_valid <= 1'b0;
         limit_copy = value;
      end
   endtask

   task automatic random_phase(input int count);
      begin
         for (int i = 0; i < count; i++) send_word(random_word(), 1'b0, '0);
      end
   endtask

   // Result side: stall in random bursts, one long hold on request
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0) burst = $urandom_range(1, 11);
         end
      end
   end

   // Compare each accepted result word with the oldest owed normal
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_word);
            errors++;
         end else begin
            want = pending_normals.pop_front();
            if (rsp_word.ok !== want.ok) begin
               $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_word.ok);
               errors++;
            end
            if (rsp_word.out_nx !== want.out_nx) begin
               $display("%0t: out_nx expected %0d actual %0d", $time, want.out_nx,
                        rsp_word.out_nx);
               errors++;
            end
            if (rsp_word.out_ny !== want.out_ny) begin
               $display("%0t: out_ny expected %0d actual %0d", $time, want.out_ny,
                        rsp_word.out_ny);
               errors++;
            end
            if (rsp_word.out_nz !== want.out_nz) begin
               $display("%0t: out_nz expected %0d actual %0d", $time, want.out_nz,
                        rsp_word.out_nz);
               errors++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CycleLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Directed rows and the phases of the run
   initial begin
      vector_row_type row;
      rsp_word_type none;
      none = '0;
      errors = 0;
      quiet = 1'b0;
      hold_cycles = 0;
      limit_copy = LimitReset;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_data = '0;

      row.typed = 1'b1;
      row.w = diag_word(4096, 4096, 4096, 4096, 0, 0);
      row.r = '{1'b1, 16'sd16384, 16'sd0, 16'sd0};
      vector_rows.insert(vector_rows.size(), row);
      row.w = diag_word(4096, 4096, 4096, 0, 4096, 0);
      row.r = '{1'b1, 16'sd0, 16'sd16384, 16'sd0};
      vector_rows.insert(vector_rows.size(), row);
      // negative determinant flips the result
      row.w = diag_word(-4096, -4096, -4096, 0, 0, 4096);
      row.r = '{1'b1, 16'sd0, 16'sd0, -16'sd16384};
      vector_rows.insert(vector_rows.size(), row);
      row.r = none;
      row.w = diag_word(0, 0, 0, 4096, 4096, 4096);
      vector_rows.insert(vector_rows.size(), row);
      // zero transformed vector
      row.w = diag_word(4096, 4096, 4096, 0, 0, 0);
      vector_rows.insert(vector_rows.size(), row);
      row.w = {12{16'h8000}};
      vector_rows.insert(vector_rows.size(), row);
      row.w = {12{16'h7fff}};
      vector_rows.insert(vector_rows.size(), row);
      // determinant right at the reset limit
      row.w = diag_word(1, 1, 687, 1, 1, 1);
      vector_rows.insert(vector_rows.size(), row);
      row.typed = 1'b0;
      row.w = diag_word(1, 1, 688, 1, 1, 1);
      vector_rows.insert(vector_rows.size(), row);
      row.w = diag_word(32767, 32767, 32767, 32767, 32767, 32767);
      vector_rows.insert(vector_rows.size(), row);
      row.w = diag_word(-32768, -32768, -32768, -32768, -32768, -32768);
      vector_rows.insert(vector_rows.size(), row);
      row.w = diag_word(4096, 4096, 4096, 0, 0, 0);
      row.w.m_00 = 0; row.w.m_01 = -4096; row.w.m_10 = 4096; row.w.m_11 = 0;
      row.w.in_nx = 4096; row.w.in_ny = 4096;
      vector_rows.insert(vector_rows.size(), row);
      row.w = {6{16'h5555, 16'haaaa}};
      vector_rows.insert(vector_rows.size(), row);
      row.w = {6{16'haaaa, 16'h5555}};
      vector_rows.insert(vector_rows.size(), row);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (vector_rows[i]) send_word(vector_rows[i].w, vector_rows[i].typed,
                                         vector_rows[i].r);
      drain();

      write_limit('0);
      random_phase(150);
      // long receiver hold while words keep coming
      hold_cycles = 300;
      random_phase(250);
      drain();

      write_limit({LimitWidth{1'b1}});
      random_phase(200);
      drain();

      write_limit(LimitWidth'({$urandom, $urandom}));
      random_phase(350);
      drain();

      write_limit(LimitWidth'($urandom_range(0, 100000)));
      random_phase(300);
      drain();

      write_limit(LimitReset);
      random_phase(200);
      quiet = 1'b1;
      random_phase(150);
      drain();

      if (errors == 0 && pending_normals.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
